### hw/rtl/cetm_pkg.sv
package cetm_pkg;

    localparam int ENTRY_COUNT_WIDTH_DEF = 16;
    localparam int NUMBER_WIDTH          = 16;
    localparam int CFG_INDEX_WIDTH       = 3;
    localparam int CFG_DATA_WIDTH        = 6;
    localparam int FIELD_COUNT           = 5;

    localparam logic [7:0] TOK_EXACT = 8'd123;
    localparam logic [7:0] TOK_ANY   = 8'd124;
    localparam logic [7:0] TOK_LIST  = 8'd125;
    localparam logic [7:0] TOK_RANGE = 8'd126;
    localparam logic [7:0] TOK_END   = 8'd127;
    localparam logic [7:0] TEXT_END  = 8'd0;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MINUTE  = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HOUR    = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DAY     = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MONTH   = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_WEEKDAY = 3'd4;

    localparam logic [2:0] FIELD_MINUTE = 3'd0;
    localparam logic [2:0] FIELD_HOUR   = 3'd1;
    localparam logic [2:0] FIELD_DAY    = 3'd2;
    localparam logic [2:0] FIELD_MONTH  = 3'd3;
    localparam logic [2:0] FIELD_LAST   = 3'd5;

    typedef enum logic [2:0] {
        PH_TOKEN,
        PH_EXACT,
        PH_LIST,
        PH_RLOW,
        PH_RHIGH,
        PH_TEXT
    } t_phase;

    typedef struct packed {
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
        logic [2:0] weekday;
    } t_time;

    typedef struct packed {
        logic                    matched;
        logic [NUMBER_WIDTH-1:0] number;
        logic                    done;
    } t_result;

endpackage

### hw/rtl/cetm_cfg_regs.sv
module cetm_cfg_regs
    import cetm_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  i_cfg_data,
    output t_time                      o_time
);

    t_time r_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time.minute  <= 6'd0;
            r_time.hour    <= 5'd0;
            r_time.day     <= 5'd1;
            r_time.month   <= 4'd1;
            r_time.weekday <= 3'd7;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MINUTE:  r_time.minute  <= i_cfg_data;
                REG_HOUR:    r_time.hour    <= i_cfg_data[4:0];
                REG_DAY:     r_time.day     <= i_cfg_data[4:0];
                REG_MONTH:   r_time.month   <= i_cfg_data[3:0];
                REG_WEEKDAY: r_time.weekday <= i_cfg_data[2:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    assign o_time = r_time;

endmodule

### hw/rtl/cetm_scan.sv
module cetm_scan
    import cetm_pkg::*;
#(
    parameter int ENTRY_COUNT_WIDTH = ENTRY_COUNT_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  t_time      i_time,
    output logic       o_res_valid,
    output t_result    o_res
);

    t_phase                       r_phase, n_phase;
    logic [2:0]                   r_field_idx, n_field_idx;
    logic                         r_mismatch, n_mismatch;
    logic                         r_list_hit, n_list_hit;
    logic [7:0]                   r_range_low, n_range_low;
    logic [ENTRY_COUNT_WIDTH-1:0] r_count, n_count;

    logic [7:0]              now_val;
    logic [NUMBER_WIDTH-1:0] number;
    logic                    range_ok;
    logic [2:0]              idx_inc;
    t_phase                  phase_after_field;

    always_comb begin
        case (r_field_idx)
            FIELD_MINUTE: now_val = {2'b00, i_time.minute};
            FIELD_HOUR:   now_val = {3'b000, i_time.hour};
            FIELD_DAY:    now_val = {3'b000, i_time.day};
            FIELD_MONTH:  now_val = {4'b0000, i_time.month};
            default:      now_val = {5'b00000, i_time.weekday};
        endcase
    end

    generate
        if (ENTRY_COUNT_WIDTH > NUMBER_WIDTH) begin : g_sat
            assign number = (|r_count[ENTRY_COUNT_WIDTH-1:NUMBER_WIDTH]) ?
                            {NUMBER_WIDTH{1'b1}} : r_count[NUMBER_WIDTH-1:0];
        end else begin : g_ext
            assign number = NUMBER_WIDTH'(r_count);
        end
    endgenerate

    // Low above high wraps; low equal to high is a single value.
    always_comb begin
        if (r_range_low < i_byte) begin
            range_ok = (now_val >= r_range_low) && (now_val <= i_byte);
        end else if (r_range_low > i_byte) begin
            range_ok = (now_val >= r_range_low) || (now_val <= i_byte);
        end else begin
            range_ok = (now_val == r_range_low);
        end
    end

    assign idx_inc           = r_field_idx + 3'd1;
    assign phase_after_field = (idx_inc >= 3'(FIELD_COUNT)) ? PH_TEXT : PH_TOKEN;

    // Next state
    always_comb begin
        n_phase     = r_phase;
        n_field_idx = r_field_idx;
        n_mismatch  = r_mismatch;
        n_list_hit  = r_list_hit;
        n_range_low = r_range_low;
        n_count     = r_count;
        if (i_step) begin
            case (r_phase)
                PH_TOKEN: begin
                    if (r_field_idx == FIELD_MINUTE && i_byte == TOK_END) begin
                        n_count    = '0;
                        n_mismatch = 1'b0;
                    end else if (i_byte == TOK_EXACT) begin
                        n_phase = PH_EXACT;
                    end else if (i_byte == TOK_ANY) begin
                        n_field_idx = idx_inc;
                        n_phase     = phase_after_field;
                    end else if (i_byte == TOK_LIST) begin
                        n_list_hit = 1'b0;
                        n_phase    = PH_LIST;
                    end else if (i_byte == TOK_RANGE) begin
                        n_phase = PH_RLOW;
                    end else begin
                        if (i_byte != now_val) n_mismatch = 1'b1;
                        n_field_idx = idx_inc;
                        n_phase     = phase_after_field;
                    end
                end
                PH_EXACT: begin
                    if (i_byte != now_val) n_mismatch = 1'b1;
                    n_field_idx = idx_inc;
                    n_phase     = phase_after_field;
                end
                PH_LIST: begin
                    if (i_byte == TOK_LIST) begin
                        if (!r_list_hit) n_mismatch = 1'b1;
                        n_list_hit  = 1'b0;
                        n_field_idx = idx_inc;
                        n_phase     = phase_after_field;
                    end else if (i_byte == now_val) begin
                        n_list_hit = 1'b1;
                    end
                end
                PH_RLOW: begin
                    n_range_low = i_byte;
                    n_phase     = PH_RHIGH;
                end
                PH_RHIGH: begin
                    if (!range_ok) n_mismatch = 1'b1;
                    n_field_idx = idx_inc;
                    n_phase     = phase_after_field;
                end
                PH_TEXT: begin
                    if (i_byte == TEXT_END) begin
                        if (r_count != {ENTRY_COUNT_WIDTH{1'b1}}) begin
                            n_count = r_count + 1'b1;
                        end
                        n_phase     = PH_TOKEN;
                        n_field_idx = FIELD_MINUTE;
                        n_mismatch  = 1'b0;
                        n_list_hit  = 1'b0;
                    end
                end
                default: n_phase = PH_TOKEN;
            endcase
        end
    end

    // Outputs
    always_comb begin
        o_res_valid  = 1'b0;
        o_res.matched = !r_mismatch;
        o_res.number  = number;
        o_res.done    = 1'b0;
        if (i_step) begin
            case (r_phase)
                PH_TOKEN: begin
                    if (r_field_idx == FIELD_MINUTE && i_byte == TOK_END) begin
                        o_res_valid   = 1'b1;
                        o_res.matched = 1'b0;
                        o_res.done    = 1'b1;
                    end
                end
                PH_TEXT: o_res_valid = (i_byte == TEXT_END);
                default: o_res_valid = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TOKEN;
            r_field_idx <= FIELD_MINUTE;
            r_mismatch  <= 1'b0;
            r_list_hit  <= 1'b0;
            r_range_low <= 8'd0;
            r_count     <= '0;
        end else begin
            r_phase     <= n_phase;
            r_field_idx <= n_field_idx;
            r_mismatch  <= n_mismatch;
            r_list_hit  <= n_list_hit;
            r_range_low <= n_range_low;
            r_count     <= n_count;
        end
    end

    a_text_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_TEXT) |-> (r_field_idx == FIELD_LAST))
        else $error("text phase with field index not at last field");

    a_field_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_TEXT) |-> (r_field_idx < FIELD_LAST))
        else $error("field index past last field outside text phase");

    a_entry_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.done) |=> (r_phase == PH_TOKEN && !r_mismatch))
        else $error("entry result did not restart the entry scan");

    a_done_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.done) |=> (r_count == '0))
        else $error("entry counter not cleared after end of table");

endmodule

### hw/rtl/cetm_out_reg.sv
module cetm_out_reg
    import cetm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    output logic    o_can_load,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    // Hold the item until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

### hw/rtl/cron_entry_time_matcher.sv
// Schedule table matcher.
// Input channel (i_in_valid / o_in_ready, i_table_byte) takes one table byte
// per item. Each entry is five field tokens (minute, hour, day, month,
// weekday) and command text closed by a zero byte; an end marker at an entry
// start closes the table.
// Output channel (o_out_valid / i_out_ready) gives one item per finished
// entry (o_entry_matched, o_entry_number) or per end of table
// (o_table_done high, o_entry_number the count of entries seen).
// The time to match sits in five registers on the write port
// (i_cfg_we, i_cfg_index, i_cfg_data); write them only while idle.
// Throughput: one byte per cycle while o_in_ready is high. The result is
// registered on the output in the cycle after the closing byte is taken.
// When the receiver stalls with a result held, o_in_ready drops until that
// item is taken; a byte that yields no result still needs the output
// register free. Reset clears the scan state, the entry counter and the
// output valid flag, and loads the time registers with 00:00, day 1, month 1,
// Sunday.
module cron_entry_time_matcher
    import cetm_pkg::*;
#(
    parameter int ENTRY_COUNT_WIDTH = ENTRY_COUNT_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [7:0]                 i_table_byte,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_entry_matched,
    output logic [NUMBER_WIDTH-1:0]    o_entry_number,
    output logic                       o_table_done
);

    t_time   cur_time;
    logic    step;
    logic    res_valid;
    t_result res;
    t_result out_res;
    logic    can_load;

    assign o_in_ready = can_load;
    assign step       = i_in_valid && can_load;

    cetm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_time      (cur_time)
    );

    cetm_scan #(
        .ENTRY_COUNT_WIDTH (ENTRY_COUNT_WIDTH)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (i_table_byte),
        .i_time      (cur_time),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    cetm_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (res_valid),
        .i_res      (res),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_res      (out_res)
    );

    assign o_entry_matched = out_res.matched;
    assign o_entry_number  = out_res.number;
    assign o_table_done    = out_res.done;

endmodule

### dv/cetm_check_pkg.sv
`timescale 1ns / 100ps

package cetm_check_pkg;

    import cetm_pkg::*;

    localparam int MAX_REPORTS = 10;

    // Time field selected by a field position; the weekday covers every later position
    function automatic logic [7:0] field_of(t_time tv, logic [2:0] k);
        logic [7:0] v;
        case (k)
            FIELD_MINUTE: v = {2'b00, tv.minute};
            FIELD_HOUR:   v = {3'b000, tv.hour};
            FIELD_DAY:    v = {3'b000, tv.day};
            FIELD_MONTH:  v = {4'b0000, tv.month};
            default:      v = {5'b00000, tv.weekday};
        endcase
        return v;
    endfunction

    class entry_scoreboard;
        t_time                   now_time;
        t_phase                  phase_q;
        logic [2:0]              field_idx;
        logic                    mismatch;
        logic                    list_hit;
        logic [7:0]              range_low;
        logic [NUMBER_WIDTH-1:0] entry_count;
        t_result                 expected_q[$];
        int                      errors;

        function new();
            now_time    = '{minute: 6'd0, hour: 5'd0, day: 5'd1, month: 4'd1, weekday: 3'd7};
            phase_q     = PH_TOKEN;
            field_idx   = FIELD_MINUTE;
            mismatch    = 1'b0;
            list_hit    = 1'b0;
            range_low   = 8'd0;
            entry_count = '0;
            errors      = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
            case (idx)
                REG_MINUTE:  now_time.minute  = data[5:0];
                REG_HOUR:    now_time.hour    = data[4:0];
                REG_DAY:     now_time.day     = data[4:0];
                REG_MONTH:   now_time.month   = data[3:0];
                REG_WEEKDAY: now_time.weekday = data[2:0];
                default: ;
            endcase
        endfunction

        function void field_done();
            field_idx = field_idx + 3'd1;
            phase_q   = (field_idx >= FIELD_LAST) ? PH_TEXT : PH_TOKEN;
        endfunction

        function void note_byte(logic [7:0] b);
            logic [7:0] v;
            logic       ok;
            t_result    r;
            v = field_of(now_time, field_idx);
            case (phase_q)
                PH_TOKEN: begin
                    if (field_idx == FIELD_MINUTE && b == TOK_END) begin
                        r.matched   = 1'b0;
                        r.number    = entry_count;
                        r.done      = 1'b1;
                        expected_q.push_back(r);
                        entry_count = '0;
                        mismatch    = 1'b0;
                    end else if (b == TOK_EXACT) begin
                        phase_q = PH_EXACT;
                    end else if (b == TOK_ANY) begin
                        field_done();
                    end else if (b == TOK_LIST) begin
                        list_hit = 1'b0;
                        phase_q  = PH_LIST;
                    end else if (b == TOK_RANGE) begin
                        phase_q = PH_RLOW;
                    end else begin
                        if (b != v) mismatch = 1'b1;
                        field_done();
                    end
                end
                PH_EXACT: begin
                    if (b != v) mismatch = 1'b1;
                    field_done();
                end
                PH_LIST: begin
                    if (b == TOK_LIST) begin
                        if (!list_hit) mismatch = 1'b1;
                        list_hit = 1'b0;
                        field_done();
                    end else if (b == v) begin
                        list_hit = 1'b1;
                    end
                end
                PH_RLOW: begin
                    range_low = b;
                    phase_q   = PH_RHIGH;
                end
                PH_RHIGH: begin
                    // a range with low above high wraps round the top
                    if (range_low < b) ok = (v >= range_low) && (v <= b);
                    else if (range_low > b) ok = (v >= range_low) || (v <= b);
                    else ok = (v == range_low);
                    if (!ok) mismatch = 1'b1;
                    field_done();
                end
                default: begin
                    if (b == TEXT_END) begin
                        r.matched = !mismatch;
                        r.number  = entry_count;
                        r.done    = 1'b0;
                        expected_q.push_back(r);
                        if (entry_count != '1) entry_count = entry_count + 1'b1;
                        phase_q   = PH_TOKEN;
                        field_idx = FIELD_MINUTE;
                        mismatch  = 1'b0;
                        list_hit  = 1'b0;
                    end
                end
            endcase
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: matched %0d number %0d done %0d",
                             got.matched, got.number, got.done);
            end else begin
                want = expected_q.pop_front();
                if (got.matched !== want.matched || got.number !== want.number ||
                    got.done !== want.done) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("result mismatch: expected matched %0d number %0d done %0d, got matched %0d number %0d done %0d",
                                 want.matched, want.number, want.done,
                                 got.matched, got.number, got.done);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit at_entry_start();
            return (phase_q == PH_TOKEN) && (field_idx == FIELD_MINUTE);
        endfunction

        // Byte that moves the scan towards the start of the next entry
        function logic [7:0] closing_byte();
            logic [7:0] b;
            case (phase_q)
                PH_TOKEN: b = TOK_ANY;
                PH_LIST:  b = TOK_LIST;
                PH_TEXT:  b = TEXT_END;
                default:  b = 8'd0;
            endcase
            return b;
        endfunction
    endclass

endpackage

### dv/cron_entry_time_matcher_tb.sv
`timescale 1ns / 100ps

module cron_entry_time_matcher_tb;

    import cetm_pkg::*;
    import cetm_check_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int PHASE_ITEMS   = 240;
    localparam int PHASE_COUNT   = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 4;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  i_cfg_data;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic [7:0]                 i_table_byte;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic                       o_entry_matched;
    logic [NUMBER_WIDTH-1:0]    o_entry_number;
    logic                       o_table_done;

    entry_scoreboard sb;
    t_time           cur_time;
    logic [7:0]      byte_queue[$];
    int              burst_left;
    int              items_sent;
    int              cycle_count;
    bit              hold_req;
    bit              hold_done;

    cron_entry_time_matcher DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_table_byte    (i_table_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_entry_matched (o_entry_matched),
        .o_entry_number  (o_entry_number),
        .o_table_done    (o_table_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic write_time(t_time tv);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_MINUTE;
        i_cfg_data  <= tv.minute;
        @(posedge i_clk);
        sb.set_reg(REG_MINUTE, tv.minute);
        i_cfg_index <= REG_HOUR;
        i_cfg_data  <= {1'b0, tv.hour};
        @(posedge i_clk);
        sb.set_reg(REG_HOUR, {1'b0, tv.hour});
        i_cfg_index <= REG_DAY;
        i_cfg_data  <= {1'b0, tv.day};
        @(posedge i_clk);
        sb.set_reg(REG_DAY, {1'b0, tv.day});
        i_cfg_index <= REG_MONTH;
        i_cfg_data  <= {2'b00, tv.month};
        @(posedge i_clk);
        sb.set_reg(REG_MONTH, {2'b00, tv.month});
        i_cfg_index <= REG_WEEKDAY;
        i_cfg_data  <= {3'b000, tv.weekday};
        @(posedge i_clk);
        sb.set_reg(REG_WEEKDAY, {3'b000, tv.weekday});
        i_cfg_we    <= 1'b0;
        cur_time = tv;
    endtask

    task automatic send_byte(logic [7:0] b);
        i_in_valid   <= 1'b1;
        i_table_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_byte(b);
        items_sent++;
    endtask

    // Insert a random gap between bursts of items
    task automatic send_paced(logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
        end
        send_byte(b);
        burst_left--;
    endtask

    task automatic send_queue();
        while (byte_queue.size() != 0) send_paced(byte_queue.pop_front());
    endtask

    // Close any partial entry, then drain before touching the time registers
    task automatic settle();
        while (!sb.at_entry_start()) send_paced(sb.closing_byte());
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_value(logic [7:0] tv);
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return tv;
        if (r < 80) return $urandom_range(0, 1) ? tv + 8'd1 : tv - 8'd1;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic push_field(logic [2:0] k);
        logic [7:0] tv;
        logic [7:0] v;
        logic [7:0] lo;
        logic [7:0] hi;
        int         n;
        tv = field_of(cur_time, k);
        case ($urandom_range(0, 9))
            0, 1: byte_queue.push_back(TOK_ANY);
            2, 3: begin
                byte_queue.push_back(TOK_EXACT);
                byte_queue.push_back(pick_value(tv));
            end
            4, 5: begin
                byte_queue.push_back(TOK_LIST);
                n = $urandom_range(0, 4);
                repeat (n) begin
                    v = pick_value(tv);
                    if (v == TOK_LIST) v = 8'd0;
                    byte_queue.push_back(v);
                end
                byte_queue.push_back(TOK_LIST);
            end
            6, 7: begin
                case ($urandom_range(0, 3))
                    0: begin
                        lo = pick_value(tv);
                        hi = lo;
                    end
                    1: begin
                        lo = tv - 8'($urandom_range(0, 3));
                        hi = tv + 8'($urandom_range(0, 3));
                    end
                    2: begin
                        lo = tv + 8'($urandom_range(0, 3));
                        hi = tv - 8'($urandom_range(1, 3));
                    end
                    default: begin
                        lo = 8'($urandom_range(0, 255));
                        hi = 8'($urandom_range(0, 255));
                    end
                endcase
                byte_queue.push_back(TOK_RANGE);
                byte_queue.push_back(lo);
                byte_queue.push_back(hi);
            end
            default: begin
                // keep a direct value clear of the token codes
                v = pick_value(tv);
                if (v >= TOK_EXACT && v <= TOK_END) v = tv;
                byte_queue.push_back(v);
            end
        endcase
    endtask

    task automatic push_entry();
        int n;
        for (int k = 0; k < FIELD_COUNT; k++) push_field(3'(k));
        n = $urandom_range(0, 5);
        repeat (n) byte_queue.push_back(8'($urandom_range(1, 255)));
        byte_queue.push_back(TEXT_END);
    endtask

    function automatic t_time phase_time(int p);
        t_time tv;
        case (p)
            0: tv = '{minute: 6'd63, hour: 5'd31, day: 5'd31, month: 4'd15, weekday: 3'd7};
            1: tv = '{minute: 6'd0, hour: 5'd0, day: 5'd0, month: 4'd0, weekday: 3'd0};
            2: tv = '{minute: 6'd59, hour: 5'd23, day: 5'd31, month: 4'd12, weekday: 3'd7};
            3: tv = '{minute: 6'd0, hour: 5'd0, day: 5'd1, month: 4'd1, weekday: 3'd1};
            PHASE_COUNT - 1: begin
                tv.minute  = 6'($urandom_range(0, 63));
                tv.hour    = 5'($urandom_range(0, 31));
                tv.day     = 5'($urandom_range(0, 31));
                tv.month   = 4'($urandom_range(0, 15));
                tv.weekday = 3'($urandom_range(0, 7));
            end
            default: begin
                tv.minute  = 6'($urandom_range(0, 59));
                tv.hour    = 5'($urandom_range(0, 23));
                tv.day     = 5'($urandom_range(1, 31));
                tv.month   = 4'($urandom_range(1, 12));
                tv.weekday = 3'($urandom_range(1, 7));
            end
        endcase
        return tv;
    endfunction

    initial begin
        int goal;
        int r;
        sb           = new();
        cur_time     = sb.now_time;
        burst_left   = 0;
        items_sent   = 0;
        hold_req     = 1'b0;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= REG_MINUTE;
        i_cfg_data   <= '0;
        i_in_valid   <= 1'b0;
        i_table_byte <= 8'd0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset time is 00:00, day 1, month 1, Sunday
        byte_queue = '{TOK_ANY, TOK_ANY, TOK_ANY, TOK_ANY, TOK_ANY, TEXT_END,
                       TOK_EXACT, 8'd0, TOK_LIST, 8'd9, 8'd0, TOK_LIST,
                       TOK_RANGE, 8'd1, 8'd1, TOK_RANGE, 8'd12, 8'd1, 8'd7,
                       TOK_END, TEXT_END, TOK_END,
                       TOK_LIST, TOK_LIST, 8'd0, TOK_RANGE, 8'd0, 8'd5,
                       TOK_ANY, TOK_ANY, TEXT_END, TOK_END};
        send_queue();
        settle();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_time(phase_time(p));
            if (p == 2) hold_req = 1'b1;
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal) begin
                r = $urandom_range(0, 99);
                if (r < 8) byte_queue.push_back(8'($urandom_range(0, 255)));
                else if (r < 14) byte_queue.push_back(TOK_END);
                else push_entry();
                send_queue();
            end
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Receiver: stall pattern chosen per span, with one long hold-off
    initial begin
        int mode;
        int span;
        int hold_count;
        hold_count  = 0;
        hold_done   = 1'b0;
        i_out_ready <= 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 120);
            for (int c = 0; c < span; c++) begin
                @(posedge i_clk);
                if (hold_req && !hold_done) begin
                    i_out_ready <= 1'b0;
                    hold_count++;
                    if (hold_count >= HOLD_CYCLES) hold_done = 1'b1;
                end else begin
                    case (mode)
                        0: i_out_ready <= 1'b1;
                        1: i_out_ready <= 1'($urandom_range(0, 1));
                        2: i_out_ready <= ($urandom_range(0, 3) == 0);
                        default: i_out_ready <= (c % 3 == 0);
                    endcase
                end
            end
        end
    end

    initial begin
        t_result got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                got.matched = o_entry_matched;
                got.number  = o_entry_number;
                got.done    = o_table_done;
                sb.check_result(got);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
